>>> design/scpu_pkg.sv
// Package with shared types and constants for the instruction step unit.
`timescale 1ns / 1ps
package scpu_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int WORD_BITS = 24;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    localparam logic [1:0] FN_WRITE = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_EXEC  = 2'd2;
    localparam logic [1:0] FN_LDPC  = 2'd3;

    localparam logic [7:0] OP_LDA  = 8'h00;
    localparam logic [7:0] OP_STA  = 8'h0C;
    localparam logic [7:0] OP_LDCH = 8'h50;
    localparam logic [7:0] OP_STCH = 8'h54;
    localparam logic [7:0] OP_ADD  = 8'h18;
    localparam logic [7:0] OP_SUB  = 8'h1C;
    localparam logic [7:0] OP_MUL  = 8'h20;
    localparam logic [7:0] OP_DIV  = 8'h24;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADOP = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_ISSUE, S_RD_WAIT, S_WR, S_EXEC, S_DIV, S_OUT
    } t_state;

    // Memory address select for the datapath.
    typedef enum logic [1:0] {
        A_IN, A_PC, A_EA
    } t_asel;

    typedef struct packed {
        logic       take_in;    // capture the input beat
        logic       mem_rd;     // read memory at asel + offset
        logic       mem_wr;     // write memory
        t_asel      asel;
        logic [1:0] offs;       // byte offset added to the address
        logic [2:0] rd_slot;    // where returned byte goes
        logic       cap_rd;     // capture returned byte
        logic       do_exec;    // apply arithmetic result
        logic       div_start;
        logic       ldpc;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] opcode;
        logic       div_busy;
    } t_stat;

    function automatic logic known_op(input logic [7:0] op);
        known_op = (op == OP_LDA) || (op == OP_STA) || (op == OP_LDCH)
            || (op == OP_STCH) || (op == OP_ADD) || (op == OP_SUB)
            || (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

>>> design/scpu_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module scpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/scpu_div.sv
// Iterative unsigned 24-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module scpu_div import scpu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_BITS-1:0] i_num,
    input  logic [WORD_BITS-1:0] i_den,
    output logic                 o_busy,
    output logic [WORD_BITS-1:0] o_quot
);
    localparam int CW = $clog2(WORD_BITS + 1);
    logic [CW-1:0]        r_cnt;
    logic [WORD_BITS-1:0] r_q;
    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_den;
    logic [WORD_BITS:0]   w_trial;
    logic [WORD_BITS:0]   w_diff;

    assign w_trial = {r_rem, r_q[WORD_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(WORD_BITS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            if (!w_diff[WORD_BITS]) begin
                r_rem <= w_diff[WORD_BITS-1:0];
                r_q   <= {r_q[WORD_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[WORD_BITS-1:0];
                r_q   <= {r_q[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
endmodule

>>> design/scpu_datapath.sv
// Datapath: memory, accumulator, program counter, operand registers, divider.
`timescale 1ns / 1ps
module scpu_datapath import scpu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [1:0]           i_func,
    input  logic [15:0]          i_addr,
    input  logic [7:0]           i_data,
    input  logic [15:0]          i_start_pc,
    output logic [49:0]          o_result
);
    logic [1:0]           r_func;
    logic [15:0]          r_addr;
    logic [7:0]           r_data;
    logic [7:0]           r_op;
    logic [15:0]          r_ea;
    logic [WORD_BITS-1:0] r_w;
    logic [7:0]           r_rd;
    logic [WORD_BITS-1:0] r_acc;
    logic [15:0]          r_pc;
    logic [1:0]           r_status;
    logic                 r_div_pend;
    logic [49:0]          r_result;

    logic [15:0]          w_base;
    logic [15:0]          w_maddr;
    logic [7:0]           w_wdata;
    logic [7:0]           w_rdata;
    logic                 w_div_busy;
    logic [WORD_BITS-1:0] w_quot;
    logic                 w_div_go;

    // A zero divisor never starts the divider, so the accumulator is kept.
    assign w_div_go = i_cmd.div_start && (r_w != '0);

    always_comb begin
        case (i_cmd.asel)
            A_IN:    w_base = r_addr;
            A_PC:    w_base = r_pc;
            // The low address byte is still arriving while the first operand read goes out.
            A_EA:    w_base = (i_cmd.cap_rd && i_cmd.rd_slot == 3'd2) ?
                              {r_ea[15:8], w_rdata} : r_ea;
            default: w_base = r_addr;
        endcase
        w_maddr = w_base + {14'd0, i_cmd.offs};
        if (r_func == FN_WRITE) begin
            w_wdata = r_data;
        end else if (r_op == OP_STA) begin
            case (i_cmd.offs)
                2'd0:    w_wdata = r_acc[23:16];
                2'd1:    w_wdata = r_acc[15:8];
                default: w_wdata = r_acc[7:0];
            endcase
        end else begin
            w_wdata = r_acc[7:0];
        end
    end

    scpu_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_wr),
        .i_addr  (w_maddr[MEM_AW-1:0]),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    scpu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   (r_acc),
        .i_den   (r_w),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_func <= i_func;
            r_addr <= i_addr;
            r_data <= i_data;
            r_rd   <= '0;
        end
        if (i_cmd.cap_rd) begin
            case (i_cmd.rd_slot)
                3'd0:    r_op         <= w_rdata;
                3'd1:    r_ea[15:8]   <= w_rdata;
                3'd2:    r_ea[7:0]    <= w_rdata;
                3'd3:    r_w[23:16]   <= w_rdata;
                3'd4:    r_w[15:8]    <= w_rdata;
                3'd5:    r_w[7:0]     <= w_rdata;
                default: r_rd         <= w_rdata;
            endcase
        end
        if (i_cmd.out_load) begin
            r_result <= {r_status, r_pc, r_acc, r_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_pc       <= '0;
            r_status   <= ST_OK;
            r_div_pend <= 1'b0;
        end else begin
            if (i_cmd.take_in) begin
                r_status <= ST_OK;
            end
            if (i_cmd.ldpc) begin
                r_pc <= i_start_pc;
            end
            if (i_cmd.do_exec) begin
                if (!known_op(r_op)) begin
                    r_pc     <= r_pc + 16'd1;
                    r_status <= ST_BADOP;
                end else begin
                    r_pc <= r_pc + 16'd3;
                    case (r_op)
                        OP_LDA:  r_acc <= r_w;
                        OP_LDCH: r_acc <= {16'd0, r_w[23:16]};
                        OP_ADD:  r_acc <= r_acc + r_w;
                        OP_SUB:  r_acc <= r_acc - r_w;
                        OP_MUL:  r_acc <= r_acc * r_w;
                        OP_DIV: begin
                            if (r_w == '0) begin
                                r_status <= ST_DIVZ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (w_div_go) begin
                r_div_pend <= 1'b1;
            end else if (r_div_pend && !w_div_busy) begin
                r_acc      <= w_quot;
                r_div_pend <= 1'b0;
            end
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.opcode   = r_op;
    assign o_stat.div_busy = w_div_busy || r_div_pend || i_cmd.div_start;
    assign o_result        = r_result;
endmodule

>>> design/scpu_ctrl.sv
// Controller state machine sequencing memory reads, writes and execution.
`timescale 1ns / 1ps
module scpu_ctrl import scpu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_ovalid;
    logic       w_known;
    logic       w_store;

    assign w_known = known_op(i_stat.opcode);
    assign w_store = (i_stat.opcode == OP_STA) || (i_stat.opcode == OP_STCH);

    // Read step numbering: 0 opcode, 1..2 address, 3..5 operand word, 6 monitor byte.
    // The opcode register holds the new opcode from step 1 on.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_state = S_RD_ISSUE;
                    n_step  = 3'd0;
                end
            end
            S_RD_ISSUE: begin
                case (i_stat.func)
                    FN_WRITE: begin
                        n_state = S_OUT;
                    end
                    FN_READ: begin
                        n_state = S_RD_WAIT;
                        n_step  = 3'd6;
                    end
                    FN_LDPC: begin
                        n_state = S_OUT;
                    end
                    default: begin
                        n_state = S_RD_WAIT;
                    end
                endcase
            end
            S_RD_WAIT: begin
                if (r_step == 3'd6) begin
                    n_state = S_OUT;
                end else if (r_step == 3'd1 && !w_known) begin
                    n_state = S_EXEC;
                end else if (r_step == 3'd2 && w_store) begin
                    n_state = S_WR;
                    n_step  = 3'd0;
                end else if (r_step == 3'd5) begin
                    n_state = S_EXEC;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_WR: begin
                if (r_step == 3'd2 || i_stat.opcode == OP_STCH) begin
                    n_state = S_EXEC;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            S_EXEC: begin
                if (i_stat.opcode == OP_DIV && w_known) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.asel     = A_IN;
        o_cmd.take_in  = (r_state == S_IDLE) && i_in_valid && o_in_ready;
        o_cmd.rd_slot  = r_step;
        case (r_state)
            S_RD_ISSUE: begin
                o_cmd.mem_wr = (i_stat.func == FN_WRITE);
                o_cmd.ldpc   = (i_stat.func == FN_LDPC);
                o_cmd.asel   = (i_stat.func == FN_EXEC) ? A_PC : A_IN;
            end
            S_RD_WAIT: begin
                o_cmd.cap_rd = 1'b1;
                if (r_step == 3'd6) begin
                    o_cmd.asel = A_IN;
                end else if (r_step <= 3'd1) begin
                    o_cmd.asel = A_PC;
                    o_cmd.offs = r_step[1:0] + 2'd1;
                end else begin
                    o_cmd.asel = A_EA;
                    o_cmd.offs = (r_step == 3'd2) ? 2'd0 : (r_step[1:0] - 2'd2);
                end
                // The address for the next read is presented while this byte returns.
                if (r_step == 3'd6) begin
                    o_cmd.offs = 2'd0;
                end
            end
            S_WR: begin
                o_cmd.asel   = A_EA;
                o_cmd.offs   = r_step[1:0];
                o_cmd.mem_wr = 1'b1;
            end
            S_EXEC: begin
                o_cmd.do_exec   = 1'b1;
                o_cmd.div_start = (i_stat.opcode == OP_DIV) && w_known;
            end
            S_OUT: begin
                o_cmd.out_load = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // A new beat is taken while the previous result is still valid only if
    // that result is accepted in the same cycle.
    assign o_in_ready  = (r_state == S_IDLE) && !(r_ovalid && !i_out_ready);
    assign o_out_valid = r_ovalid;
endmodule

>>> design/sic_subset_cpu_step_unit.sv
// Top level of the accumulator machine instruction step unit.
//   Channel | Dir | Signals                      | Contents
//   s_axis  | in  | tvalid tready tdata[31:0]    | func, addr, data
//   m_axis  | out | tvalid tready tdata[55:0]    | read_data, acc, pc, status
//   cfg     | in  | i_cfg_we i_cfg_wdata[15:0]   | start_pc
// How long a byte write, pc load, byte read or instruction takes is set by the
// byte-wide memory port, one byte per cycle with a registered read, and by the
// bit-serial divider for a divide.
// Reset is synchronous, active low, and clears accumulator, pc and start_pc.
// A result waits in an output register; a stalled output holds further beats.
`timescale 1ns / 1ps
module sic_subset_cpu_step_unit import scpu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // func[1:0], addr[17:2], data[25:18], zeros
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // read_data[7:0], acc[31:8], pc[47:32], status[49:48]
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    logic [15:0] r_start_pc;
    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [49:0] w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= '0;
        end else if (i_cfg_we) begin
            r_start_pc <= i_cfg_wdata;
        end
    end

    scpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    scpu_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_func     (s_axis_tdata[1:0]),
        .i_addr     (s_axis_tdata[17:2]),
        .i_data     (s_axis_tdata[25:18]),
        .i_start_pc (r_start_pc),
        .o_result   (w_result)
    );

    assign m_axis_tdata = {6'd0, w_result};
endmodule

>>> verif/sic_subset_cpu_step_unit_tb.sv
// Self-checking testbench for the accumulator machine instruction step unit.
`timescale 1ns / 1ps
module sic_subset_cpu_step_unit_tb;
    import scpu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc;
        logic [23:0] acc;
        logic [7:0]  read_data;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // func[1:0], addr[17:2], data[25:18], zeros
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // read_data[7:0], acc[31:8], pc[47:32], status[49:48]
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    sic_subset_cpu_step_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Machine state as predicted.
    logic [7:0]  shadow_mem [0:MEM_BYTES-1];
    bit          mem_written [0:MEM_BYTES-1];
    logic [23:0] shadow_acc;
    logic [15:0] shadow_pc;
    logic [15:0] shadow_start_pc;

    t_result expected_results[$];
    int      error_count;
    int      idle_cycles;
    int      send_idle_pct;
    int      stall_pct;
    bit      done;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [7:0] mem_rd(input logic [15:0] a);
        return shadow_mem[a];
    endfunction

    function automatic void mem_wr(input logic [15:0] a, input logic [7:0] v);
        shadow_mem[a] = v;
        mem_written[a] = 1'b1;
    endfunction

    function automatic logic [23:0] word_at(input logic [15:0] a);
        return {mem_rd(a), mem_rd(a + 16'd1), mem_rd(a + 16'd2)};
    endfunction

    function automatic logic [1:0] step_instruction();
        logic [7:0]  op;
        logic [15:0] ea;
        logic [23:0] w;
        logic [47:0] prod;
        op = mem_rd(shadow_pc);
        if (!known_op(op)) begin
            shadow_pc = shadow_pc + 16'd1;
            return ST_BADOP;
        end
        ea = {mem_rd(shadow_pc + 16'd1), mem_rd(shadow_pc + 16'd2)};
        shadow_pc = shadow_pc + 16'd3;
        w = word_at(ea);
        case (op)
            OP_LDA: shadow_acc = w;
            OP_STA: begin
                mem_wr(ea, shadow_acc[23:16]);
                mem_wr(ea + 16'd1, shadow_acc[15:8]);
                mem_wr(ea + 16'd2, shadow_acc[7:0]);
            end
            OP_LDCH: shadow_acc = {16'd0, mem_rd(ea)};
            OP_STCH: mem_wr(ea, shadow_acc[7:0]);
            OP_ADD:  shadow_acc = shadow_acc + w;
            OP_SUB:  shadow_acc = shadow_acc - w;
            OP_MUL: begin
                prod = shadow_acc * w;
                shadow_acc = prod[23:0];
            end
            default: begin
                if (w == 24'd0) return ST_DIVZ;
                shadow_acc = shadow_acc / w;
            end
        endcase
        return ST_OK;
    endfunction

    function automatic t_result predict_step(input logic [1:0] fn, input logic [15:0] a,
                                             input logic [7:0] d);
        t_result r;
        r = '0;
        case (fn)
            FN_WRITE: mem_wr(a, d);
            FN_READ:  r.read_data = mem_rd(a);
            FN_EXEC:  r.status = step_instruction();
            default:  shadow_pc = shadow_start_pc;
        endcase
        r.acc = shadow_acc;
        r.pc = shadow_pc;
        return r;
    endfunction

    // Leaves tvalid high after the beat; a drain lowers it, and so may an idle gap before the next beat.
    task automatic send_beat(input logic [1:0] fn, input logic [15:0] a, input logic [7:0] d);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, d, a, fn};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(predict_step(fn, a, d));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_start_pc(input logic [15:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        shadow_start_pc = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_word(input logic [15:0] a, input logic [23:0] v);
        send_beat(FN_WRITE, a, v[23:16]);
        send_beat(FN_WRITE, a + 16'd1, v[15:8]);
        send_beat(FN_WRITE, a + 16'd2, v[7:0]);
    endtask

    // Places one instruction at the current pc and executes it.
    task automatic run_instr(input logic [7:0] op, input logic [15:0] ea);
        logic [15:0] p;
        p = shadow_pc;
        send_beat(FN_WRITE, p, op);
        send_beat(FN_WRITE, p + 16'd1, ea[15:8]);
        send_beat(FN_WRITE, p + 16'd2, ea[7:0]);
        send_beat(FN_EXEC, 16'd0, 8'd0);
    endtask

    task automatic test_directed();
        logic [7:0] ops[8];
        ops = '{OP_LDA, OP_STA, OP_LDCH, OP_STCH, OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        write_start_pc(16'hFFFE);
        send_beat(FN_LDPC, 16'hFFFF, 8'hFF);
        write_word(16'h0000, 24'hFFFFFF);
        send_beat(FN_READ, 16'h0000, 8'h00);
        // Instruction straddles the top of memory.
        run_instr(OP_LDA, 16'h0000);
        run_instr(OP_ADD, 16'h0000);
        write_word(16'hFFFF, 24'h000000);
        run_instr(OP_DIV, 16'hFFFF);
        run_instr(8'hFF, 16'h1234);
        foreach (ops[i]) run_instr(ops[i], 16'h0000);
    endtask

    // Random programs: mostly valid instructions on a small data window.
    task automatic test_random(input int n);
        int k;
        logic [7:0] ops[8];
        logic [15:0] a;
        ops = '{OP_LDA, OP_STA, OP_LDCH, OP_STCH, OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0: send_beat(FN_WRITE, 16'($urandom), 8'($urandom));
                1: begin
                    a = 16'($urandom);
                    if (mem_written[a]) send_beat(FN_READ, a, 8'd0);
                    else send_beat(FN_WRITE, a, 8'($urandom));
                end
                2: begin
                    a = 16'($urandom);
                    write_word(a, $urandom_range(3) == 0 ? 24'd0 : 24'($urandom));
                    run_instr(ops[3'($urandom_range(7))], a);
                end
                3: begin
                    a = 16'($urandom);
                    write_word(a, 24'($urandom));
                    run_instr(8'($urandom), a);
                end
                4: send_beat(FN_LDPC, 16'($urandom), 8'($urandom));
                default: begin
                    a = 16'h4000 + 16'($urandom_range(7) * 3);
                    write_word(a, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(9)));
                    run_instr(ops[3'($urandom_range(7))], a);
                end
            endcase
        end
    endtask

    // Checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[49:0];
            if (expected_results.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.read_data !== want.read_data) begin
                    $error("read_data exp %h got %h", want.read_data, got.read_data);
                    error_count++;
                end
                if (got.acc !== want.acc) begin
                    $error("acc exp %h got %h", want.acc, got.acc);
                    error_count++;
                end
                if (got.pc !== want.pc) begin
                    $error("pc exp %h got %h", want.pc, got.pc);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status exp %h got %h", want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog on cycles without any accepted beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        done = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        shadow_acc = '0;
        shadow_pc = '0;
        shadow_start_pc = '0;
        foreach (mem_written[i]) mem_written[i] = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(90);
        write_start_pc(16'h0000);
        send_idle_pct = 67;
        test_random(90);
        wait_drained();
        write_start_pc(16'h4000);
        send_idle_pct = 0;
        stall_pct = 67;
        test_random(90);
        write_start_pc(16'h8001);
        send_idle_pct = 7;
        stall_pct = 7;
        test_random(90);
        send_idle_pct = 0;
        stall_pct = 0;
        wait_drained();
        done = 1'b1;
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
